/* src/infix_to_postfix_converter_core_defines.svh */
// ----------------------------------------------------------------------------
// Infix to postfix converter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_DEFINES_SVH

// same-cycle implication
`define I2P_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define I2P_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/i2p_pkg.sv */
// ----------------------------------------------------------------------------
// Infix to postfix converter package
// Stack sizing, character codes, stack operation codes and payload types.
// ----------------------------------------------------------------------------
package i2p_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_NOOPEN = 2'd2;

	typedef logic [2:0] stk_op_t;

	localparam stk_op_t STK_HOLD = 3'd0;
	localparam stk_op_t STK_PUSH = 3'd1;
	localparam stk_op_t STK_POP  = 3'd2;
	localparam stk_op_t STK_POP2 = 3'd3;
	localparam stk_op_t STK_REPL = 3'd4;

	typedef struct packed {
		logic       action;
		logic [7:0] in_char;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       last_of_run;
		logic [1:0] status;
	} out_item_t;

	function automatic logic [1:0] prec_of(input logic [7:0] c);
		logic [1:0] p;
		case (c)
			CH_PLUS, CH_MINUS: p = 2'd1;
			CH_STAR, CH_SLASH: p = 2'd2;
			CH_CARET:          p = 2'd3;
			default:           p = 2'd0;
		endcase
		return p;
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			((c >= 8'h61) && (c <= 8'h7A));
	endfunction

endpackage

/* src/i2p_cell.sv */
// ----------------------------------------------------------------------------
// Infix to postfix converter stack cell
// One entry of the shifting operator stack; takes its neighbor's entry.
// ----------------------------------------------------------------------------
module i2p_cell (
	input  logic              clk,
	input  i2p_pkg::stk_op_t  op,
	input  logic [7:0]        up_data,
	input  logic [7:0]        dn1_data,
	input  logic [7:0]        dn2_data,
	output logic [7:0]        data
);

	logic [7:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			i2p_pkg::STK_PUSH: data_q <= up_data;
			i2p_pkg::STK_POP:  data_q <= dn1_data;
			i2p_pkg::STK_POP2: data_q <= dn2_data;
			default:           data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

/* src/infix_to_postfix_converter_core.sv */
// ----------------------------------------------------------------------------
// Infix to postfix converter core
// Shunting-yard conversion over a shifting chain of operator stack cells.
// ----------------------------------------------------------------------------
// An input character is transferred in and then yields a run of result items
// (at least one), one item per cycle when results are taken at once; the
// stack top is read and popped once a cycle through the cell chain, which
// sets that rate. The next input is taken as soon as the last result of the
// run sits in the output register.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_core_defines.svh"

module infix_to_postfix_converter_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  i2p_pkg::in_item_t    item_data,
	output logic                 result_valid,
	input  logic                 result_ready,
	output i2p_pkg::out_item_t   result_data
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WORK = 1'b1;
	localparam int   DEPTH   = i2p_pkg::STACK_DEPTH;
	localparam int   CW      = i2p_pkg::CNT_W;

	logic                    state_q;
	logic                    act_q;
	logic [7:0]              chr_q;
	logic [CW-1:0]           cnt_q;
	logic                    result_valid_q;
	i2p_pkg::out_item_t      result_q;

	logic [7:0]              cell_data [DEPTH];
	i2p_pkg::stk_op_t        cell_op   [DEPTH];
	logic [7:0]              cell_up   [DEPTH];
	logic [7:0]              cell_dn1  [DEPTH];
	logic [7:0]              cell_dn2  [DEPTH];

	logic                    step;
	logic                    empty;
	logic                    one;
	logic                    full;
	logic [7:0]              top;
	logic [7:0]              nxt;
	logic [1:0]              p_in;
	i2p_pkg::stk_op_t        op;
	i2p_pkg::out_item_t      item;
	logic [CW-1:0]           cnt_d;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	assign step  = (state_q == ST_WORK) && (!result_valid_q || result_ready);
	assign empty = (cnt_q == '0);
	assign one   = (cnt_q == CW'(1));
	assign full  = (cnt_q == CW'(DEPTH));
	assign top   = cell_data[0];
	assign nxt   = cell_data[1];
	assign p_in  = i2p_pkg::prec_of(chr_q);

	always_comb begin
		op               = i2p_pkg::STK_HOLD;
		item.out_char    = 8'h00;
		item.char_valid  = 1'b0;
		item.last_of_run = 1'b1;
		item.status      = i2p_pkg::ST_OK;
		if (act_q) begin
			if (!empty) begin
				op               = i2p_pkg::STK_POP;
				item.out_char    = top;
				item.char_valid  = 1'b1;
				item.last_of_run = one;
			end
		end else if (i2p_pkg::is_alnum(chr_q)) begin
			item.out_char   = chr_q;
			item.char_valid = 1'b1;
		end else if (chr_q == i2p_pkg::CH_OPEN) begin
			if (full) begin
				item.status = i2p_pkg::ST_FULL;
			end else begin
				op = i2p_pkg::STK_PUSH;
			end
		end else if (chr_q == i2p_pkg::CH_CLOSE) begin
			if (empty) begin
				item.status = i2p_pkg::ST_NOOPEN;
			end else if (top == i2p_pkg::CH_OPEN) begin
				op = i2p_pkg::STK_POP;
			end else begin
				item.out_char    = top;
				item.char_valid  = 1'b1;
				if (one) begin
					op          = i2p_pkg::STK_POP;
					item.status = i2p_pkg::ST_NOOPEN;
				end else if (nxt == i2p_pkg::CH_OPEN) begin
					op = i2p_pkg::STK_POP2;
				end else begin
					op               = i2p_pkg::STK_POP;
					item.last_of_run = 1'b0;
				end
			end
		end else begin
			if (!empty && (p_in <= i2p_pkg::prec_of(top))) begin
				item.out_char   = top;
				item.char_valid = 1'b1;
				if (one || (p_in > i2p_pkg::prec_of(nxt))) begin
					op = i2p_pkg::STK_REPL;
				end else begin
					op               = i2p_pkg::STK_POP;
					item.last_of_run = 1'b0;
				end
			end else if (full) begin
				item.status = i2p_pkg::ST_FULL;
			end else begin
				op = i2p_pkg::STK_PUSH;
			end
		end
	end

	always_comb begin
		case (op)
			i2p_pkg::STK_PUSH: cnt_d = cnt_q + CW'(1);
			i2p_pkg::STK_POP:  cnt_d = cnt_q - CW'(1);
			i2p_pkg::STK_POP2: cnt_d = cnt_q - CW'(2);
			default:           cnt_d = cnt_q;
		endcase
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_up[i]  = (i == 0) ? chr_q : cell_data[(i == 0) ? 0 : i - 1];
			cell_dn1[i] = (i + 1 < DEPTH) ? cell_data[(i + 1 < DEPTH) ? i + 1 : i] : 8'h00;
			cell_dn2[i] = (i + 2 < DEPTH) ? cell_data[(i + 2 < DEPTH) ? i + 2 : i] : 8'h00;
			if (!step) begin
				cell_op[i] = i2p_pkg::STK_HOLD;
			end else if (op == i2p_pkg::STK_REPL) begin
				cell_op[i] = (i == 0) ? i2p_pkg::STK_PUSH : i2p_pkg::STK_HOLD;
			end else begin
				cell_op[i] = op;
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		i2p_cell u_cell (
			.clk      (clk),
			.op       (cell_op[g]),
			.up_data  (cell_up[g]),
			.dn1_data (cell_dn1[g]),
			.dn2_data (cell_dn2[g]),
			.data     (cell_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				state_q <= ST_WORK;
			end else if (step && item.last_of_run) begin
				state_q <= ST_IDLE;
			end
			if (step) begin
				cnt_q          <= cnt_d;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			act_q <= item_data.action;
			chr_q <= item_data.in_char;
		end
		if (step) begin
			result_q <= item;
		end
	end

	`I2P_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH), "stack count beyond depth")
	`I2P_ASSERT_NOW(a_pop_nonempty, step && (op == i2p_pkg::STK_POP || op == i2p_pkg::STK_POP2 || op == i2p_pkg::STK_REPL), !empty, "pop on empty stack")
	`I2P_ASSERT_NOW(a_status_last, result_valid_q && (result_q.status != i2p_pkg::ST_OK), result_q.last_of_run, "status on inner item")
	`I2P_ASSERT_NOW(a_empty_last, result_valid_q && !result_q.char_valid, result_q.last_of_run, "empty item not last")
	`I2P_ASSERT_NEXT(a_accept_busy, item_valid && item_ready, !item_ready, "transfer did not start work")

endmodule

/* dv/infix_to_postfix_converter_core_checker.sv */
// ----------------------------------------------------------------------------
// Infix to postfix converter checker
// Watches both channels of the core. It keeps its own operator stack, works
// out the postfix run that each input transfer must cause, and compares every
// result transfer field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_ready,
	input  i2p_pkg::in_item_t    item_data,
	input  logic                 result_valid,
	input  logic                 result_ready,
	input  i2p_pkg::out_item_t   result_data,
	output int                   mismatches,
	output int                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import i2p_pkg::*;

	logic [7:0] op_stack [STACK_DEPTH];
	int         stack_fill = 0;
	out_item_t  postfix_q[$];

	initial mismatches = 0;

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 100)
			$display("[%0t] postfix mismatch: %s", $time, what);
	endtask

	function automatic int op_rank(input logic [7:0] c);
		int r;
		case (c)
			CH_PLUS, CH_MINUS: r = 1;
			CH_STAR, CH_SLASH: r = 2;
			CH_CARET:          r = 3;
			default:           r = 0;
		endcase
		return r;
	endfunction

	function automatic bit is_operand_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic void convert_char(input in_item_t it);
		logic [7:0] emitted[$];
		logic [1:0] st;
		int         rank;
		out_item_t  res;
		st = ST_OK;
		if (it.action) begin
			while (stack_fill > 0) begin
				stack_fill--;
				emitted.push_back(op_stack[stack_fill]);
			end
		end else if (is_operand_char(it.in_char)) begin
			emitted.push_back(it.in_char);
		end else if (it.in_char == CH_OPEN) begin
			if (stack_fill < STACK_DEPTH) begin
				op_stack[stack_fill] = it.in_char;
				stack_fill++;
			end else begin
				st = ST_FULL;
			end
		end else if (it.in_char == CH_CLOSE) begin
			while (stack_fill > 0 && op_stack[stack_fill - 1] != CH_OPEN) begin
				stack_fill--;
				emitted.push_back(op_stack[stack_fill]);
			end
			if (stack_fill > 0)
				stack_fill--;
			else
				st = ST_NOOPEN;
		end else begin
			rank = op_rank(it.in_char);
			while (stack_fill > 0 && rank <= op_rank(op_stack[stack_fill - 1])) begin
				stack_fill--;
				emitted.push_back(op_stack[stack_fill]);
			end
			if (stack_fill < STACK_DEPTH) begin
				op_stack[stack_fill] = it.in_char;
				stack_fill++;
			end else begin
				st = ST_FULL;
			end
		end
		if (emitted.size() == 0) begin
			res.out_char    = 8'h00;
			res.char_valid  = 1'b0;
			res.last_of_run = 1'b1;
			res.status      = st;
			postfix_q.push_back(res);
		end else begin
			for (int i = 0; i < emitted.size(); i++) begin
				res.out_char    = emitted[i];
				res.char_valid  = 1'b1;
				res.last_of_run = (i == emitted.size() - 1);
				res.status      = (i == emitted.size() - 1) ? st : ST_OK;
				postfix_q.push_back(res);
			end
		end
	endfunction

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (postfix_q.size() == 0) begin
			report_mismatch($sformatf("result with nothing outstanding: %h", got));
		end else begin
			want = postfix_q.pop_front();
			if (got.out_char !== want.out_char)
				report_mismatch($sformatf("out_char %h, want %h", got.out_char, want.out_char));
			if (got.char_valid !== want.char_valid)
				report_mismatch($sformatf("char_valid %b, want %b",
					got.char_valid, want.char_valid));
			if (got.last_of_run !== want.last_of_run)
				report_mismatch($sformatf("last_of_run %b, want %b",
					got.last_of_run, want.last_of_run));
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_fill = 0;
			postfix_q.delete();
			outstanding <= 0;
		end else begin
			if (result_valid && result_ready)
				check_result(result_data);
			if (item_valid && item_ready)
				convert_char(item_data);
			outstanding <= postfix_q.size();
		end
	end

endmodule

/* dv/infix_to_postfix_converter_core_test.sv */
// ----------------------------------------------------------------------------
// Infix to postfix converter testbench
// Feeds the core a directed set of expressions and edge characters, then
// random well-formed expressions, broken ones, noise bytes and deep nesting
// that can overflow the operator stack, under three idling mixes and a long
// result back-pressure stretch. The checker beside the core does the scoring.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import i2p_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_ready;
	in_item_t  item_data;
	logic      result_valid;
	logic      result_ready;
	out_item_t result_data;
	int        mismatches;
	int        outstanding;

	int         send_idle_pct = 15;
	int         recv_idle_pct = 71;
	int         hold_requests = 0;
	int         phase_items   = 0;
	logic [7:0] infix_q[$];
	logic [7:0] op_set [5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};

	infix_to_postfix_converter_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item_data    (item_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

	infix_to_postfix_converter_core_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item_data    (item_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("** infix_to_postfix_converter_core: FAILED **");
		$finish;
	end

	// hold off results for a long stretch on request
	initial begin
		int hold_left;
		int served;
		hold_left    = 0;
		served       = 0;
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (served != hold_requests) begin
				served    = hold_requests;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_char(input logic act, input logic [7:0] ch);
		int gap;
		in_item_t it;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.action  = act;
		it.in_char = ch;
		item_valid <= 1'b1;
		item_data  <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		phase_items++;
	endtask

	task automatic wait_drained;
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] operand_char;
		logic [7:0] c;
		case ($urandom_range(2))
			0:       c = "0" + $urandom_range(9);
			1:       c = "A" + $urandom_range(25);
			default: c = "a" + $urandom_range(25);
		endcase
		return c;
	endfunction

	function automatic void gen_expr(input int depth);
		int pick;
		pick = $urandom_range(99);
		if (depth == 0 || pick < 35) begin
			infix_q.push_back(operand_char());
		end else if (pick < 55) begin
			infix_q.push_back(CH_OPEN);
			gen_expr(depth - 1);
			infix_q.push_back(CH_CLOSE);
		end else begin
			gen_expr(depth - 1);
			infix_q.push_back(op_set[$urandom_range(4)]);
			gen_expr(depth - 1);
		end
	endfunction

	task automatic send_expression(input bit broken);
		logic [7:0] c;
		infix_q.delete();
		gen_expr($urandom_range(1, 4));
		while (infix_q.size() > 0) begin
			c = infix_q.pop_front();
			if (broken && $urandom_range(5) == 0) begin
				case ($urandom_range(3))
					0:       send_char(1'b0, CH_OPEN);
					1:       send_char(1'b0, CH_CLOSE);
					2:       send_char(1'b0, op_set[$urandom_range(4)]);
					default: send_char(1'b0, 8'($urandom_range(255)));
				endcase
			end
			send_char(1'b0, c);
		end
		if (!broken || $urandom_range(1))
			send_char(1'b1, 8'($urandom_range(255)));
	endtask

	task automatic send_deep_nest;
		repeat ($urandom_range(30, 36))
			send_char(1'b0, CH_OPEN);
		send_char(1'b0, operand_char());
		send_char(1'b0, op_set[$urandom_range(4)]);
		send_char(1'b0, operand_char());
		repeat ($urandom_range(0, 3))
			send_char(1'b0, CH_CLOSE);
		send_char(1'b1, 8'($urandom_range(255)));
	endtask

	task automatic send_random(input int count);
		int pick;
		while (phase_items < count) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				send_expression(1'b0);
			end else if (pick < 85) begin
				send_expression(1'b1);
			end else if (pick < 96) begin
				repeat ($urandom_range(1, 6))
					send_char($urandom_range(4) == 0, 8'($urandom_range(255)));
			end else begin
				send_deep_nest();
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item_data  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_char(1'b1, 8'h00);
		send_char(1'b0, CH_CLOSE);
		send_char(1'b0, "0");
		send_char(1'b0, "z");
		send_char(1'b0, 8'h00);
		send_char(1'b0, 8'hFF);
		send_char(1'b0, CH_OPEN);
		send_char(1'b0, CH_PLUS);
		send_char(1'b0, CH_STAR);
		send_char(1'b0, CH_CARET);
		send_char(1'b0, CH_CARET);
		send_char(1'b0, CH_MINUS);
		send_char(1'b0, CH_SLASH);
		send_char(1'b0, CH_CLOSE);
		send_char(1'b0, CH_CLOSE);
		send_char(1'b0, CH_OPEN);
		send_char(1'b0, "#");
		send_char(1'b0, CH_OPEN);
		send_char(1'b0, "x");
		send_char(1'b1, 8'hA5);
		wait_drained();

		phase_items = 0;
		send_random(50);
		wait_drained();

		send_idle_pct = 71;
		recv_idle_pct = 15;
		phase_items   = 0;
		send_random(50);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		phase_items   = 0;
		hold_requests++;
		send_deep_nest();
		send_random(50);
		wait_drained();

		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("** infix_to_postfix_converter_core: PASSED **");
		else
			$display("** infix_to_postfix_converter_core: FAILED **");
		$finish;
	end

endmodule
